// File: rtl/lgpc_pkg.sv
// Shared types and constants for the linear gradient pixel colour block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lgpc_pkg;

    localparam int IDX_W           = 12;
    localparam int CH_W            = 8;
    localparam int NUM_CH          = 3;
    localparam int COLOR_W         = NUM_CH * CH_W;
    localparam int DIM_W           = 13;
    localparam int DIM_LIMIT       = (1 << DIM_W) - 1;
    localparam int PROD_W          = IDX_W + CH_W;
    localparam int CFG_IDX_W       = 3;
    localparam int MAX_DIM_DEFAULT = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_COLOR  = 3'd0,
        REG_END_COLOR    = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic bypass;
    } ctrl_t;

    typedef struct packed {
        logic            neg;
        logic [CH_W-1:0] start;
    } lane_hdr_t;

endpackage

// File: rtl/linear_gradient_pixel_color.sv
// Top level of the linear gradient pixel colour block: configuration registers,
// input skid stage, front stage, a chain of division cells and the result register.
// Depends on lgpc_pkg, lgpc_prep and lgpc_cell.
// A pixel request carries column and row on the pix channel (pix_valid, pix_stall);
// the colour comes back as blue, green and red bytes on the rgb channel (rgb_valid,
// rgb_stall). Registers are written through cfg_valid, cfg_ready, cfg_index and
// cfg_data; the user must do so only while no request is in flight, which the block
// itself does not enforce. cfg_ready is always high. Each accepted request passes
// through the front stage register, the division chain (one cell per bit of the
// 20-bit product) and the result register, where it waits until it is taken. One
// request per clock is taken and returned as long as the receiver does not stall.
// Reset empties the pipeline, clears the colours to black and sets both dimensions
// to one. While a waiting result is stalled, the chain holds; a single input request
// is then parked in the skid register and pix_stall rises in the following cycle.
`timescale 1ns / 1ps

module linear_gradient_pixel_color #(
    parameter int MAX_DIM = lgpc_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic [lgpc_pkg::IDX_W-1:0]       column,
    input  logic [lgpc_pkg::IDX_W-1:0]       row,
    output logic                             rgb_valid,
    input  logic                             rgb_stall,
    output logic [lgpc_pkg::CH_W-1:0]        blue,
    output logic [lgpc_pkg::CH_W-1:0]        green,
    output logic [lgpc_pkg::CH_W-1:0]        red,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgpc_pkg::COLOR_W-1:0]     cfg_data
);

    import lgpc_pkg::*;

    // The divisor is the gradient length minus one, so it never needs more
    // bits than the largest usable length.
    localparam int EFF_MAX = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
    localparam int DIV_W   = $clog2(EFF_MAX);

    // Configuration registers.
    logic [COLOR_W-1:0] start_color_reg;
    logic [COLOR_W-1:0] end_color_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;

    // Skid stage and flow control.
    logic               advance;
    logic               pix_acc;
    logic               skid_full_reg;
    logic               skid_full_next;
    logic [IDX_W-1:0]   skid_col_reg;
    logic [IDX_W-1:0]   skid_row_reg;
    logic               front_valid;
    logic [IDX_W-1:0]   front_col;
    logic [IDX_W-1:0]   front_row;

    // Chain of stages: index 0 is the front stage, index PROD_W the last cell.
    logic [DIV_W-1:0]               dvs;
    ctrl_t                          stg_ctrl [0:PROD_W];
    lane_hdr_t [NUM_CH-1:0]         stg_hdr  [0:PROD_W];
    logic [NUM_CH-1:0][PROD_W-1:0]  stg_num  [0:PROD_W];
    logic [NUM_CH-1:0][DIV_W-1:0]   stg_rem  [0:PROD_W];
    logic [NUM_CH-1:0][CH_W-1:0]    stg_quo  [0:PROD_W];

    // Result register.
    logic                           rgb_valid_reg;
    logic [NUM_CH-1:0][CH_W-1:0]    rgb_reg;
    logic [NUM_CH-1:0][CH_W-1:0]    rgb_next;

    // ------------------------------------------------------------------
    // Configuration port. Every write is taken at once; an index outside
    // the register list is ignored.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg  <= '0;
            end_color_reg    <= '0;
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_COLOR:  start_color_reg  <= cfg_data;
                REG_END_COLOR:    end_color_reg    <= cfg_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The whole chain moves when the result register is empty
    // or being taken. The skid register catches a request that arrives in
    // the cycle the chain stops, so pix_stall comes straight from a flop.
    // ------------------------------------------------------------------
    assign advance   = !rgb_valid_reg || !rgb_stall;
    assign pix_stall = skid_full_reg;
    assign pix_acc   = pix_valid && !skid_full_reg;

    assign front_valid = skid_full_reg || pix_valid;
    assign front_col   = skid_full_reg ? skid_col_reg : column;
    assign front_row   = skid_full_reg ? skid_row_reg : row;

    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = !advance;
        end
        else
        begin
            skid_full_next = pix_acc && !advance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc && !advance)
        begin
            skid_col_reg <= column;
            skid_row_reg <= row;
        end
    end

    // ------------------------------------------------------------------
    // Front stage: axis choice, divisor and the unsigned products.
    // ------------------------------------------------------------------
    lgpc_prep #(
        .MAX_DIM (MAX_DIM),
        .DIV_W   (DIV_W)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .front_valid  (front_valid),
        .column       (front_col),
        .row          (front_row),
        .start_color  (start_color_reg),
        .end_color    (end_color_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .dvs          (dvs),
        .ctrl_reg     (stg_ctrl[0]),
        .hdr_reg      (stg_hdr[0]),
        .num_reg      (stg_num[0])
    );

    // The division starts from an empty remainder and quotient.
    assign stg_rem[0] = '0;
    assign stg_quo[0] = '0;

    // ------------------------------------------------------------------
    // Division chain: each cell brings down one product bit, compares the
    // partial remainder with the divisor and shifts one quotient bit in.
    // Only the low byte of the quotient is kept, as only the low byte of
    // the colour survives.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < PROD_W; k++)
    begin : g_cell
        lgpc_cell #(
            .DIV_W (DIV_W),
            .STEP  (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .dvs      (dvs),
            .ctrl_in  (stg_ctrl[k]),
            .hdr_in   (stg_hdr[k]),
            .num_in   (stg_num[k]),
            .rem_in   (stg_rem[k]),
            .quo_in   (stg_quo[k]),
            .ctrl_reg (stg_ctrl[k+1]),
            .hdr_reg  (stg_hdr[k+1]),
            .num_reg  (stg_num[k+1]),
            .rem_reg  (stg_rem[k+1]),
            .quo_reg  (stg_quo[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Result. The quotient is a magnitude and the sign of start minus end rides in the
    // lane header, so a falling channel subtracts it and a rising one adds it back. A
    // gradient of length one or zero gives the start colour.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (stg_ctrl[PROD_W].bypass)
            begin
                rgb_next[c] = stg_hdr[PROD_W][c].start;
            end
            else if (stg_hdr[PROD_W][c].neg)
            begin
                rgb_next[c] = stg_hdr[PROD_W][c].start + stg_quo[PROD_W][c];
            end
            else
            begin
                rgb_next[c] = stg_hdr[PROD_W][c].start - stg_quo[PROD_W][c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rgb_valid_reg <= stg_ctrl[PROD_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stg_ctrl[PROD_W].valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = rgb_valid_reg;
    assign blue      = rgb_reg[0];
    assign green     = rgb_reg[1];
    assign red       = rgb_reg[2];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The skid register only fills in a cycle in which the chain was held.
    a_skid_fill_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> !$past(advance))
        else $error("skid register filled while the chain was moving");

    // A parked request enters the front stage as soon as the chain moves.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_full_reg && advance) |=> stg_ctrl[0].valid)
        else $error("parked request was lost when the chain moved");

    // A request leaving the last cell always lands in the result register.
    a_chain_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stg_ctrl[PROD_W].valid) |=> rgb_valid_reg)
        else $error("request from the division chain did not reach the output");

endmodule

// File: rtl/lgpc_prep.sv
// Front stage: picks the gradient axis, forms the divisor and the three
// index-times-difference products. Depends on lgpc_pkg.
`timescale 1ns / 1ps

module lgpc_prep #(
    parameter int MAX_DIM = lgpc_pkg::MAX_DIM_DEFAULT,
    parameter int DIV_W   = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  logic                                          front_valid,
    input  logic [lgpc_pkg::IDX_W-1:0]                    column,
    input  logic [lgpc_pkg::IDX_W-1:0]                    row,
    input  logic [lgpc_pkg::COLOR_W-1:0]                  start_color,
    input  logic [lgpc_pkg::COLOR_W-1:0]                  end_color,
    input  logic [lgpc_pkg::DIM_W-1:0]                    image_width,
    input  logic [lgpc_pkg::DIM_W-1:0]                    image_height,
    output logic [DIV_W-1:0]                              dvs,
    output lgpc_pkg::ctrl_t                               ctrl_reg,
    output lgpc_pkg::lane_hdr_t [lgpc_pkg::NUM_CH-1:0]    hdr_reg,
    output logic [lgpc_pkg::NUM_CH-1:0][lgpc_pkg::PROD_W-1:0] num_reg
);

    import lgpc_pkg::*;

    localparam int CLAMP = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
    localparam logic [DIM_W-1:0] CLAMP_V = DIM_W'(CLAMP);

    logic [DIM_W-1:0]                  w_clamp;
    logic [DIM_W-1:0]                  h_clamp;
    logic [DIM_W-1:0]                  len;
    logic [DIM_W-1:0]                  len_m1;
    logic [IDX_W-1:0]                  idx;
    logic                              bypass;
    logic [NUM_CH-1:0][CH_W-1:0]       s_b;
    logic [NUM_CH-1:0][CH_W-1:0]       e_b;
    logic [NUM_CH-1:0][CH_W:0]         diff;
    logic [NUM_CH-1:0][CH_W-1:0]       mag;
    ctrl_t                             ctrl_next;
    lane_hdr_t [NUM_CH-1:0]            hdr_next;
    logic [NUM_CH-1:0][PROD_W-1:0]     num_next;

    // The axis and length follow from the registers alone; the user must write them only
    // while the block is idle, which the block itself does not enforce.
    always_comb
    begin
        w_clamp = (image_width > CLAMP_V) ? CLAMP_V : image_width;
        h_clamp = (image_height > CLAMP_V) ? CLAMP_V : image_height;
        if (h_clamp > w_clamp)
        begin
            idx = row;
            len = h_clamp;
        end
        else
        begin
            idx = column;
            len = w_clamp;
        end
        bypass = (len <= DIM_W'(1));
        len_m1 = len - DIM_W'(1);
    end

    assign dvs = len_m1[DIV_W-1:0];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            s_b[c]            = start_color[c*CH_W +: CH_W];
            e_b[c]            = end_color[c*CH_W +: CH_W];
            diff[c]           = {1'b0, s_b[c]} - {1'b0, e_b[c]};
            mag[c]            = diff[c][CH_W] ? CH_W'(-diff[c]) : diff[c][CH_W-1:0];
            num_next[c]       = PROD_W'(idx) * PROD_W'(mag[c]);
            hdr_next[c].neg   = diff[c][CH_W];
            hdr_next[c].start = s_b[c];
        end
        ctrl_next.valid  = front_valid;
        ctrl_next.bypass = bypass;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && front_valid)
        begin
            hdr_reg <= hdr_next;
            num_reg <= num_next;
        end
    end

endmodule

// File: rtl/lgpc_cell.sv
// One restoring division step for all three colour lanes, one quotient bit each.
// Depends on lgpc_pkg.
`timescale 1ns / 1ps

module lgpc_cell #(
    parameter int DIV_W = 12,
    parameter int STEP  = 0
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               advance,
    input  logic [DIV_W-1:0]                                   dvs,
    input  lgpc_pkg::ctrl_t                                    ctrl_in,
    input  lgpc_pkg::lane_hdr_t [lgpc_pkg::NUM_CH-1:0]         hdr_in,
    input  logic [lgpc_pkg::NUM_CH-1:0][lgpc_pkg::PROD_W-1:0]  num_in,
    input  logic [lgpc_pkg::NUM_CH-1:0][DIV_W-1:0]             rem_in,
    input  logic [lgpc_pkg::NUM_CH-1:0][lgpc_pkg::CH_W-1:0]    quo_in,
    output lgpc_pkg::ctrl_t                                    ctrl_reg,
    output lgpc_pkg::lane_hdr_t [lgpc_pkg::NUM_CH-1:0]         hdr_reg,
    output logic [lgpc_pkg::NUM_CH-1:0][lgpc_pkg::PROD_W-1:0]  num_reg,
    output logic [lgpc_pkg::NUM_CH-1:0][DIV_W-1:0]             rem_reg,
    output logic [lgpc_pkg::NUM_CH-1:0][lgpc_pkg::CH_W-1:0]    quo_reg
);

    import lgpc_pkg::*;

    // Dividend bit brought down by this cell, most significant first.
    localparam int BIT_POS = PROD_W - 1 - STEP;

    logic [NUM_CH-1:0][DIV_W:0]   trial;
    logic [NUM_CH-1:0][DIV_W:0]   trial_sub;
    logic [NUM_CH-1:0]            ge;
    logic [NUM_CH-1:0][DIV_W-1:0] rem_next;
    logic [NUM_CH-1:0][CH_W-1:0]  quo_next;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            trial[c]     = {rem_in[c], num_in[c][BIT_POS]};
            ge[c]        = (trial[c] >= {1'b0, dvs});
            trial_sub[c] = trial[c] - {1'b0, dvs};
            rem_next[c]  = ge[c] ? trial_sub[c][DIV_W-1:0] : trial[c][DIV_W-1:0];
            quo_next[c]  = {quo_in[c][CH_W-2:0], ge[c]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl_in.valid)
        begin
            hdr_reg <= hdr_in;
            num_reg <= num_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// File: sim/tb.sv
// Self-checking testbench for linear_gradient_pixel_color: directed and random pixel requests,
// checked against a behavioural gradient predictor kept in step with the register writes.
// Depends on lgpc_pkg and the RTL of linear_gradient_pixel_color.
`timescale 1ns / 1ps

module tb;

    import lgpc_pkg::*;

    // Run limits. The tail wait comfortably covers any stray result that might still turn up.
    localparam int GRAD_MAX_DIM  = MAX_DIM_DEFAULT;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_PIXELS  = 52;

    // An index the register map does not decode: a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 pix_valid;
    logic                 pix_stall;
    logic [IDX_W-1:0]     column;
    logic [IDX_W-1:0]     row;
    logic                 rgb_valid;
    logic                 rgb_stall;
    logic [CH_W-1:0]      blue;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      red;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    // Shadow copy of the gradient registers, updated on every accepted write.
    logic [COLOR_W-1:0]   grad_start;
    logic [COLOR_W-1:0]   grad_end;
    logic [DIM_W-1:0]     grad_width;
    logic [DIM_W-1:0]     grad_height;

    // Colours still owed by the block, oldest first.
    rgb_pixel_t           owed_pixels[$];

    int                   error_count;
    int                   cycle_count;
    int                   stall_hold;
    bit                   idling_on;

    linear_gradient_pixel_color #(
        .MAX_DIM(GRAD_MAX_DIM)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .column    (column),
        .row       (row),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Gradient predictor
    // ------------------------------------------------------------------

    // Dimensions larger than the synthesised maximum behave as the maximum.
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d);
        return (d > GRAD_MAX_DIM) ? GRAD_MAX_DIM : int'(d);
    endfunction

    // One channel: start minus index times (start - end) over (length - 1), with the
    // division truncating towards zero and only the low byte kept. A length of zero
    // or one has no valid divisor and simply yields the start byte.
    function automatic logic [CH_W-1:0] blend_byte(input logic [CH_W-1:0] s,
                                                   input logic [CH_W-1:0] e,
                                                   input int unsigned     idx,
                                                   input int unsigned     len);
        longint ls;
        longint le;
        longint li;
        longint ln;
        longint quot;
        longint mixed;
        ls = s;
        le = e;
        li = idx;
        ln = len;
        if (len <= 1)
        begin
            return s;
        end
        quot  = (li * (ls - le)) / (ln - 1);
        mixed = ls - quot;
        return mixed[CH_W-1:0];
    endfunction

    // A tall image grades down the rows; otherwise the gradient runs across the columns
    // and the row index plays no part.
    function automatic rgb_pixel_t gradient_pixel(input logic [IDX_W-1:0] col,
                                                  input logic [IDX_W-1:0] rw);
        rgb_pixel_t  px;
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned len;
        w = clamp_dim(grad_width);
        h = clamp_dim(grad_height);
        if (h > w)
        begin
            idx = rw;
            len = h;
        end
        else
        begin
            idx = col;
            len = w;
        end
        px.blue  = blend_byte(grad_start[7:0],   grad_end[7:0],   idx, len);
        px.green = blend_byte(grad_start[15:8],  grad_end[15:8],  idx, len);
        px.red   = blend_byte(grad_start[23:16], grad_end[23:16], idx, len);
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Request driver and register writer
    // ------------------------------------------------------------------

    // Sends one pixel request. Inputs change on the falling edge; acceptance is judged on
    // the rising edge from the stall seen there. The valid is left high afterwards so
    // that back-to-back requests stream without a bubble; park_requests lowers it.
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] rw);
        int gap;
        gap = idling_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        column    <= col;
        row       <= rw;
        do @(posedge clk); while (pix_stall);
        owed_pixels.push_back(gradient_pixel(col, rw));
    endtask

    task automatic park_requests();
        @(negedge clk);
        pix_valid <= 1'b0;
    endtask

    // Stops sending and waits for every owed colour, which leaves the pipeline empty.
    task automatic drain_pixels();
        park_requests();
        while (owed_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0]   data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_START_COLOR:  grad_start  = data;
            REG_END_COLOR:    grad_end    = data;
            REG_IMAGE_WIDTH:  grad_width  = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: grad_height = data[DIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Reprogramming is only safe with nothing in flight, so drain first.
    task automatic set_gradient(input logic [COLOR_W-1:0] s, input logic [COLOR_W-1:0] e,
                                input logic [COLOR_W-1:0] w, input logic [COLOR_W-1:0] h);
        drain_pixels();
        write_register(REG_START_COLOR, s);
        write_register(REG_END_COLOR, e);
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver back-pressure
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    // Every colour accepted on the rising edge is matched with the oldest owed one. After
    // each accepted colour the receiver draws how many cycles it will stall next.
    always @(posedge clk)
    begin
        rgb_pixel_t want;
        cycle_count++;
        if (rst_n && rgb_valid && !rgb_stall)
        begin
            if (owed_pixels.size() == 0)
            begin
                report_mismatch($sformatf("colour b=%02h g=%02h r=%02h with no request owed",
                                          blue, green, red));
            end
            else
            begin
                want = owed_pixels.pop_front();
                if (blue !== want.blue)
                    report_mismatch($sformatf("blue %02h, expected %02h", blue, want.blue));
                if (green !== want.green)
                    report_mismatch($sformatf("green %02h, expected %02h", green, want.green));
                if (red !== want.red)
                    report_mismatch($sformatf("red %02h, expected %02h", red, want.red));
            end
            stall_hold = idling_on ? $urandom_range(0, 3) : 0;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("linear_gradient_pixel_color verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            rgb_stall <= 1'b1;
            stall_hold--;
        end
        else
        begin
            rgb_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset both dimensions are one and both colours black, so every pixel,
    // even at the far corner, must come back black.
    task automatic test_reset_defaults();
        send_pixel('0, '0);
        send_pixel('1, '1);
    endtask

    // Full-swing and 16-by-16 gradients across the columns. The row index is irrelevant, so
    // it is driven to assorted values; a short image shows an index far past the end colour.
    task automatic test_column_gradient();
        set_gradient(24'hFFFFFF, 24'h000000, 13'd4096, 13'd1);
        send_pixel(12'd0,    12'hFFF);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd2048, 12'h555);
        set_gradient(24'h12A0FF, 24'hF0105A, 13'd16, 13'd16);
        send_pixel(12'd15,   12'hAAA);
        send_pixel(12'd4095, 12'd7);
    endtask

    // Height exceeding width turns the gradient down the rows.
    task automatic test_row_gradient();
        set_gradient(24'h000000, 24'hFFFFFF, 13'd3, 13'd4096);
        send_pixel(12'hFFF, 12'd0);
        send_pixel(12'd0,   12'd4095);
        send_pixel(12'd1,   12'd1000);
        send_pixel(12'd2,   12'd4094);
    endtask

    // Dimensions above the maximum are clamped before the direction is chosen, so a
    // width of 8191 against a height of 4097 still grades across the columns. A zero
    // length falls back to the start colour like a length of one.
    task automatic test_dimension_corners();
        set_gradient(24'h80FF01, 24'h7F00FE, 13'd8191, 13'd4097);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd100,  12'd3);
        set_gradient(24'hC3A55A, 24'h3C5AA5, 13'd0, 13'd0);
        send_pixel(12'd4095, 12'd4095);
        set_gradient(24'hC3A55A, 24'h3C5AA5, 13'd0, 13'd2);
        send_pixel(12'd0,    12'd1);
        send_pixel(12'd0,    12'd4095);
    endtask

    // Only the low thirteen bits of a dimension write count, and an undecoded index
    // must leave the programmed gradient untouched.
    task automatic test_register_decode();
        set_gradient(24'h00FF80, 24'hFF0080, 24'hFFE005, 24'h7FC003);
        write_register(REG_UNMAPPED, 24'hFFFFFF);
        send_pixel(12'd4, 12'd2);
        send_pixel(12'd2, 12'd0);
    endtask

    function automatic logic [DIM_W-1:0] pick_dimension();
        case ($urandom_range(0, 9))
            0:       return 13'd1;
            1:       return 13'd0;
            2:       return 13'd4096;
            3:       return 13'd8191;
            4:       return 13'($urandom_range(4097, 8190));
            5:       return 13'($urandom_range(2, 4096));
            default: return 13'($urandom_range(2, 48));
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_colour();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // Random phases: a fresh gradient per phase, then a run of pixel requests. Most
    // requests sit inside the gradient length; a few fall anywhere in the index range.
    // Some phases run flat out with no idling on either side, and some stop partway
    // until every owed colour has arrived before carrying on.
    task automatic test_random_gradients();
        logic [COLOR_W-1:0] wdata;
        logic [COLOR_W-1:0] hdata;
        logic [IDX_W-1:0]   along;
        logic [IDX_W-1:0]   across;
        int unsigned        len;
        int                 pause_at;
        bit                 by_rows;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wdata = {11'd0, pick_dimension()};
            hdata = {11'd0, pick_dimension()};
            if ($urandom_range(0, 5) == 0)
                wdata[COLOR_W-1:DIM_W] = 11'($urandom_range(0, 2047));
            if ($urandom_range(0, 5) == 0)
                hdata[COLOR_W-1:DIM_W] = 11'($urandom_range(0, 2047));
            set_gradient(pick_colour(), pick_colour(), wdata, hdata);
            idling_on = (p != 0) && ($urandom_range(0, 3) != 0);
            by_rows   = clamp_dim(grad_height) > clamp_dim(grad_width);
            len       = by_rows ? clamp_dim(grad_height) : clamp_dim(grad_width);
            pause_at  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, PHASE_PIXELS - 1) : -1;
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if (i == pause_at)
                    drain_pixels();
                if (len >= 1 && $urandom_range(0, 7) != 0)
                    along = 12'($urandom_range(0, len - 1));
                else
                    along = 12'($urandom_range(0, 4095));
                across = 12'($urandom_range(0, 4095));
                if (by_rows)
                    send_pixel(across, along);
                else
                    send_pixel(along, across);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        column      = '0;
        row         = '0;
        rgb_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_START_COLOR;
        cfg_data    = '0;
        grad_start  = '0;
        grad_end    = '0;
        grad_width  = 13'd1;
        grad_height = 13'd1;
        error_count = 0;
        cycle_count = 0;
        stall_hold  = 0;
        idling_on   = 1'b1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_column_gradient();
        test_row_gradient();
        test_dimension_corners();
        test_register_decode();
        test_random_gradients();

        // Wait for the last colour, then a little longer in case anything extra appears.
        drain_pixels();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (owed_pixels.size() != 0)
            report_mismatch($sformatf("%0d colours never arrived", owed_pixels.size()));

        if (error_count == 0)
        begin
            $display("linear_gradient_pixel_color verification clean");
        end
        else
        begin
            $display("linear_gradient_pixel_color verification failed");
        end
        $finish;
    end

endmodule

// File: linear_gradient_pixel_color.f
rtl/lgpc_pkg.sv
rtl/lgpc_prep.sv
rtl/lgpc_cell.sv
rtl/linear_gradient_pixel_color.sv
sim/tb.sv
